/* hdl/tcps_pkg.sv */
// ----------------------------------------------------------------------------
// Thread class pick scheduler package
// Shared widths, codes and payload types.
// ----------------------------------------------------------------------------
package tcps_pkg;
   localparam int SLOTS = 16;
   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SETREQ = 3'd1;
   localparam logic [2:0] OP_PICK = 3'd2;
   localparam logic [2:0] OP_STOP = 3'd3;
   localparam logic [2:0] OP_BLOCK = 3'd4;
   localparam logic [2:0] OP_UNBLOCK = 3'd5;
   localparam logic [2:0] OP_TERM = 3'd6;
   localparam logic [2:0] OP_TERMALL = 3'd7;

   localparam logic [1:0] ST_FREE = 2'd0;
   localparam logic [1:0] ST_RUNNABLE = 2'd1;
   localparam logic [1:0] ST_RUNNING = 2'd2;
   localparam logic [1:0] ST_BLOCKED = 2'd3;

   localparam logic [1:0] KIND_USER = 2'd0;
   localparam logic [1:0] KIND_ATOMIC = 2'd1;
   localparam logic [1:0] KIND_KERNEL = 2'd2;

   localparam logic [2:0] RS_OK = 3'd0;
   localparam logic [2:0] RS_WAIT = 3'd1;
   localparam logic [2:0] RS_BUSY = 3'd2;
   localparam logic [2:0] RS_EXIT = 3'd3;
   localparam logic [2:0] RS_BAD = 3'd4;

   typedef struct packed {
      logic [2:0] opcode;
      logic [3:0] slot;
      logic want_syscall;
      logic want_atomic;
      logic may_syscall;
      logic may_atomic;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] grant_slot;
      logic grant_kernel;
      logic grant_atomic;
   } rsp_type;
endpackage

/* hdl/tcps_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one scheduler operation.
// ----------------------------------------------------------------------------
interface tcps_req_if;
   logic valid;
   logic ready;
   tcps_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hdl/tcps_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one scheduler result.
// ----------------------------------------------------------------------------
interface tcps_rsp_if;
   logic valid;
   logic ready;
   tcps_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hdl/thread_class_pick_scheduler.sv */
// ----------------------------------------------------------------------------
// Thread class pick scheduler
// Slot table with an ordered runnable list, walked one entry per cycle.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// req       in         opcode, slot, request and capability bits
// rsp       out        status, granted slot and grant kind
// A pick scans the runnable list, then decides; a granted pick walks the list
// again to remove the granted slot. A successful block or terminate walks the
// list once to remove its slot; other operations are decoded straight to the result.
// Reset clears the slot table and the list count.
// req is not ready while an operation runs or its result waits on rsp.
module thread_class_pick_scheduler (
   input logic clock,
   input logic reset,
   tcps_req_if.sink req,
   tcps_rsp_if.source rsp
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_GRANT = 3'd3;
   localparam logic [2:0] S_RM = 3'd4;
   localparam logic [2:0] S_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   tcps_pkg::req_type op_ff, op_in;
   logic [1:0] st_ff [tcps_pkg::SLOTS], st_in [tcps_pkg::SLOTS];
   logic [tcps_pkg::SLOTS-1:0] sys_ff, sys_in, atm_ff, atm_in;
   logic [1:0] kind_ff [tcps_pkg::SLOTS], kind_in [tcps_pkg::SLOTS];
   logic [tcps_pkg::SW-1:0] ord_ff [tcps_pkg::SLOTS], ord_in [tcps_pkg::SLOTS];
   logic [tcps_pkg::CW-1:0] cnt_ff, cnt_in, rd_ff, rd_in, wr_ff, wr_in;
   logic [tcps_pkg::SW-1:0] tgt_ff, tgt_in;
   logic kf_ff, kf_in, af_ff, af_in, uf_ff, uf_in;
   logic [tcps_pkg::SW-1:0] ks_ff, ks_in, as_ff, as_in, us_ff, us_in;
   tcps_pkg::rsp_type res_ff, res_in;
   logic [tcps_pkg::SW-1:0] sl, cur;
   logic [1:0] cst;
   logic run_u, run_a, run_k, blk;
   logic [tcps_pkg::SW-1:0] pk;
   logic gate, none_act;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data = res_ff;
   assign sl = op_ff.slot[tcps_pkg::SW-1:0];
   assign cst = st_ff[sl];
   assign cur = ord_ff[rd_ff[tcps_pkg::SW-1:0]];

   always_comb begin
      run_u = 1'b0; run_a = 1'b0; run_k = 1'b0; blk = 1'b0;
      for (int i = 0; i < tcps_pkg::SLOTS; i++) begin
         if (st_ff[i] == tcps_pkg::ST_RUNNING) begin
            if (kind_ff[i] == tcps_pkg::KIND_KERNEL) run_k = 1'b1;
            else if (kind_ff[i] == tcps_pkg::KIND_ATOMIC) run_a = 1'b1;
            else run_u = 1'b1;
         end else if (st_ff[i] == tcps_pkg::ST_BLOCKED) begin
            blk = 1'b1;
         end
      end
   end

   always_comb begin
      if (op_ff.may_syscall && kf_ff) gate = !run_u && !run_a;
      else if (op_ff.may_atomic && (run_k || kf_ff)) gate = 1'b0;
      else if (op_ff.may_atomic && af_ff) gate = !run_u && !run_k;
      else if (run_k || kf_ff || run_a || af_ff) gate = 1'b0;
      else gate = uf_ff;
      none_act = !run_u && !run_a && !run_k && (cnt_ff == '0);
      if (op_ff.may_syscall && kf_ff) pk = ks_ff;
      else if (af_ff) pk = as_ff;
      else pk = us_ff;
   end

   always_comb begin
      state_in = state_ff; op_in = op_ff; st_in = st_ff; sys_in = sys_ff;
      atm_in = atm_ff; kind_in = kind_ff; ord_in = ord_ff; cnt_in = cnt_ff;
      rd_in = rd_ff; wr_in = wr_ff; tgt_in = tgt_ff; res_in = res_ff;
      kf_in = kf_ff; af_in = af_ff; uf_in = uf_ff;
      ks_in = ks_ff; as_in = as_ff; us_in = us_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in = req.data;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            res_in = '0;
            rd_in = '0; wr_in = '0; tgt_in = sl;
            kf_in = 1'b0; af_in = 1'b0; uf_in = 1'b0;
            state_in = S_OUT;
            case (op_ff.opcode)
               tcps_pkg::OP_ADD: begin
                  if (cst != tcps_pkg::ST_FREE) res_in.status = tcps_pkg::RS_BAD;
                  else begin
                     st_in[sl] = tcps_pkg::ST_RUNNABLE;
                     sys_in[sl] = 1'b0; atm_in[sl] = 1'b0;
                     kind_in[sl] = tcps_pkg::KIND_USER;
                     if (cnt_ff < tcps_pkg::CW'(tcps_pkg::SLOTS)) begin
                        ord_in[cnt_ff[tcps_pkg::SW-1:0]] = sl;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
               end
               tcps_pkg::OP_SETREQ: begin
                  if (cst == tcps_pkg::ST_FREE) res_in.status = tcps_pkg::RS_BAD;
                  else begin
                     sys_in[sl] = op_ff.want_syscall;
                     atm_in[sl] = op_ff.want_atomic;
                  end
               end
               tcps_pkg::OP_PICK: state_in = S_SCAN;
               tcps_pkg::OP_STOP: begin
                  if (cst != tcps_pkg::ST_RUNNING) res_in.status = tcps_pkg::RS_BAD;
                  else begin
                     if (kind_ff[sl] == tcps_pkg::KIND_KERNEL) sys_in[sl] = 1'b0;
                     else if (kind_ff[sl] == tcps_pkg::KIND_ATOMIC) atm_in[sl] = 1'b0;
                     st_in[sl] = tcps_pkg::ST_RUNNABLE;
                     if (cnt_ff < tcps_pkg::CW'(tcps_pkg::SLOTS)) begin
                        ord_in[cnt_ff[tcps_pkg::SW-1:0]] = sl;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
               end
               tcps_pkg::OP_BLOCK: begin
                  if (cst != tcps_pkg::ST_RUNNABLE && cst != tcps_pkg::ST_RUNNING)
                     res_in.status = tcps_pkg::RS_BAD;
                  else begin
                     st_in[sl] = tcps_pkg::ST_BLOCKED;
                     state_in = S_RM;
                  end
               end
               tcps_pkg::OP_UNBLOCK: begin
                  if (cst != tcps_pkg::ST_BLOCKED) res_in.status = tcps_pkg::RS_BAD;
                  else begin
                     st_in[sl] = tcps_pkg::ST_RUNNABLE;
                     if (cnt_ff < tcps_pkg::CW'(tcps_pkg::SLOTS)) begin
                        ord_in[cnt_ff[tcps_pkg::SW-1:0]] = sl;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
               end
               tcps_pkg::OP_TERM: begin
                  if (cst == tcps_pkg::ST_FREE) res_in.status = tcps_pkg::RS_BAD;
                  else begin
                     st_in[sl] = tcps_pkg::ST_FREE;
                     sys_in[sl] = 1'b0; atm_in[sl] = 1'b0;
                     state_in = S_RM;
                  end
               end
               default: begin
                  for (int i = 0; i < tcps_pkg::SLOTS; i++) st_in[i] = tcps_pkg::ST_FREE;
                  sys_in = '0; atm_in = '0; cnt_in = '0;
               end
            endcase
         end
         S_SCAN: begin
            if (rd_ff == cnt_ff) state_in = S_GRANT;
            else begin
               if (sys_ff[cur]) begin
                  if (!kf_ff) ks_in = cur;
                  kf_in = 1'b1;
               end else if (atm_ff[cur]) begin
                  if (!af_ff) as_in = cur;
                  af_in = 1'b1;
               end else begin
                  if (!uf_ff) us_in = cur;
                  uf_in = 1'b1;
               end
               rd_in = rd_ff + 1'b1;
            end
         end
         S_GRANT: begin
            state_in = S_OUT;
            if (none_act && !blk) res_in.status = tcps_pkg::RS_EXIT;
            else if (!gate && !none_act) res_in.status = tcps_pkg::RS_BUSY;
            else if (!((op_ff.may_syscall && kf_ff) || af_ff || uf_ff))
               res_in.status = tcps_pkg::RS_WAIT;
            else begin
               res_in.grant_slot = 4'(pk);
               res_in.grant_kernel = sys_ff[pk];
               res_in.grant_atomic = atm_ff[pk];
               kind_in[pk] = sys_ff[pk] ? tcps_pkg::KIND_KERNEL :
                             (atm_ff[pk] ? tcps_pkg::KIND_ATOMIC : tcps_pkg::KIND_USER);
               st_in[pk] = tcps_pkg::ST_RUNNING;
               tgt_in = pk; rd_in = '0; wr_in = '0;
               state_in = S_RM;
            end
         end
         S_RM: begin
            if (rd_ff == cnt_ff) begin
               cnt_in = wr_ff;
               state_in = S_OUT;
            end else begin
               if (cur != tgt_ff) begin
                  ord_in[wr_ff[tcps_pkg::SW-1:0]] = cur;
                  wr_in = wr_ff + 1'b1;
               end
               rd_in = rd_ff + 1'b1;
            end
         end
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < tcps_pkg::SLOTS; i++) begin
            st_ff[i] <= tcps_pkg::ST_FREE;
            kind_ff[i] <= tcps_pkg::KIND_USER;
         end
         sys_ff <= '0; atm_ff <= '0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         st_ff <= st_in; kind_ff <= kind_in;
         sys_ff <= sys_in; atm_ff <= atm_in; cnt_ff <= cnt_in;
      end
      op_ff <= op_in; ord_ff <= ord_in; rd_ff <= rd_in; wr_ff <= wr_in;
      tgt_ff <= tgt_in; res_ff <= res_in;
      kf_ff <= kf_in; af_ff <= af_in; uf_ff <= uf_in;
      ks_ff <= ks_in; as_ff <= as_in; us_ff <= us_in;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= tcps_pkg::CW'(tcps_pkg::SLOTS)) else $error("list count overflow");
   a_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_RM) |-> rd_ff <= cnt_ff)
      else $error("walk beyond list");
   a_wr: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RM |-> wr_ff <= rd_ff) else $error("compaction ahead of read");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(res_ff))
      else $error("result dropped");
endmodule
